/* rtl/core/circular_buffer_deque_assert.svh */
// Assertion macros used by the circular buffer deque top level.
`ifndef CIRCULAR_BUFFER_DEQUE_ASSERT_SVH
`define CIRCULAR_BUFFER_DEQUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cdq_pkg.sv */
// Package with the types and constants of the circular buffer deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_REAR  = 3'd5
    } req_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

endpackage

/* rtl/core/cdq_req_if.sv */
// Request channel interface of the circular buffer deque.
interface cdq_req_if;
    logic                        valid;
    logic                        ready;
    logic [cdq_pkg::REQ_W-1:0]   req_type;
    logic signed [cdq_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink (input valid, input req_type, input push_value, output ready);
endinterface

/* rtl/core/cdq_res_if.sv */
// Result channel interface of the circular buffer deque.
interface cdq_res_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [cdq_pkg::DATA_W-1:0] read_value;
    logic [cdq_pkg::CNT_W-1:0]         count;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output ok, output read_value, output count,
                    output is_empty, output is_full, input ready);
    modport sink (input valid, input ok, input read_value, input count,
                  input is_empty, input is_full, output ready);
endinterface

/* rtl/core/cdq_cell.sv */
// One storage cell of the deque's shifting chain.
module cdq_cell (
    input  logic                      clk,
    input  cdq_pkg::cell_ctl_t        ctl,
    input  logic [cdq_pkg::DATA_W-1:0] left_data,
    input  logic [cdq_pkg::DATA_W-1:0] right_data,
    input  logic [cdq_pkg::DATA_W-1:0] load_data,
    output logic [cdq_pkg::DATA_W-1:0] data
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            CELL_FROM_LEFT:  data_reg <= left_data;
            CELL_FROM_RIGHT: data_reg <= right_data;
            CELL_LOAD:       data_reg <= load_data;
            default:         data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;
endmodule

/* rtl/core/circular_buffer_deque.sv */
// Top level of the circular buffer deque: request control and the cell chain.
//
// The deque takes requests on the req channel (valid/ready, req_type and
// push_value) and returns exactly one result per request on the res channel.
// Elements live in a row of cells with the front element always in cell 0;
// a push or pop at the front shifts the whole row by one cell, while a push
// at the rear loads the cell just past the last element.
// A request is decoded and executed in the cycle it is accepted, and its
// result sits in the output register from the next cycle.  One request can
// be accepted every cycle while the receiver takes each result.  The output
// register separates the two sides, so a new request is taken whenever the
// register is empty or its result is being taken in the same cycle.  When
// the receiver stalls, the result stays put and req.ready falls until it
// goes.  Reset empties the deque and sets the capacity to sixteen; the cell
// contents are left as they are.  A write on cfg_we sets the capacity (zero
// becomes one, anything above sixteen becomes sixteen) and empties the deque;
// the user must make it only while no request is in flight; no check is made.

`include "circular_buffer_deque_assert.svh"

module circular_buffer_deque (
    input  logic                       clk,
    input  logic                       rst_n,
    cdq_req_if.sink                    req,
    cdq_res_if.source                  res,
    input  logic                       cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]  cfg_wdata
);
    import cdq_pkg::*;

    // Control state.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic             res_valid_reg;

    // Result payload, held while the receiver stalls.
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic [CNT_W-1:0]  count_out_reg;
    logic              is_empty_reg;
    logic              is_full_reg;

    logic              accept;
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  rear_idx;
    logic [IDX_W-1:0]  push_idx;
    logic [DATA_W-1:0] push_data;

    cell_ctl_t         cell_ctl  [DEPTH];
    logic [DATA_W-1:0] cell_data [DEPTH];

    // A new request may enter whenever the output register is free or is
    // being emptied in this very cycle.
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= cap_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign rear_idx  = count_m1[IDX_W-1:0];
    // A rear push only happens when not full, so the count is below DEPTH.
    assign push_idx  = count_reg[IDX_W-1:0];
    assign push_data = req.push_value;

    // Request decode: the result and the move each cell makes.
    always_comb
    begin
        ok_next         = 1'b0;
        read_value_next = '1;
        count_next      = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctl[i].op = CELL_HOLD;
        end

        if (accept)
        begin
            case (req.req_type)
                REQ_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            cell_ctl[i].op = CELL_FROM_LEFT;
                        end
                    end
                end
                REQ_PUSH_REAR:
                begin
                    if (!full)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        cell_ctl[push_idx].op = CELL_LOAD;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        ok_next         = 1'b1;
                        read_value_next = cell_data[0];
                        count_next      = count_m1;
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            cell_ctl[i].op = CELL_FROM_RIGHT;
                        end
                    end
                end
                REQ_POP_REAR:
                begin
                    if (!empty)
                    begin
                        ok_next         = 1'b1;
                        read_value_next = cell_data[rear_idx];
                        count_next      = count_m1;
                    end
                end
                REQ_PEEK_FRONT:
                begin
                    if (!empty)
                    begin
                        ok_next         = 1'b1;
                        read_value_next = cell_data[0];
                    end
                end
                REQ_PEEK_REAR:
                begin
                    if (!empty)
                    begin
                        ok_next         = 1'b1;
                        read_value_next = cell_data[rear_idx];
                    end
                end
                default:
                begin
                    // Unused request codes change nothing and report failure.
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Capacity written through the configuration port is clamped to 1..DEPTH.
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_next = CNT_W'(1);
        else if (cfg_wdata > CNT_W'(DEPTH))
            cap_next = CNT_W'(DEPTH);
        else
            cap_next = cfg_wdata;
    end

    // The row of cells. Cell 0 takes the pushed value from its left, and the
    // last cell refills from itself when the row shifts towards the front.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        cdq_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[g]),
            .left_data  ((g == 0) ? push_data : cell_data[(g == 0) ? 0 : g - 1]),
            .right_data (cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .load_data  (push_data),
            .data       (cell_data[g])
        );
    end

    // Control registers. A capacity write also empties the deque.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg   <= cap_next;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end

            if (accept)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok_next;
            read_value_reg <= read_value_next;
            count_out_reg  <= count_next;
            is_empty_reg   <= (count_next == '0);
            is_full_reg    <= (count_next == cap_reg);
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.ok         = ok_reg;
    assign res.read_value = read_value_reg;
    assign res.count      = count_out_reg;
    assign res.is_empty   = is_empty_reg;
    assign res.is_full    = is_full_reg;

    // The count never exceeds the capacity, and the capacity stays in range.
    `CDQ_ASSERT_NOW(a_count_le_cap, 1'b1, count_reg <= cap_reg, "count above capacity")
    `CDQ_ASSERT_NOW(a_cap_range, 1'b1, (cap_reg != '0) && (cap_reg <= CNT_W'(DEPTH)),
                    "capacity out of range")
    // A capacity write leaves the deque empty.
    `CDQ_ASSERT_NEXT(a_cfg_empties, cfg_we, count_reg == '0, "capacity write did not empty")
    // A successful push grows the count by exactly one.
    `CDQ_ASSERT_NEXT(a_push_grows,
                     accept && !cfg_we && !full &&
                     (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_REAR),
                     count_reg == $past(count_reg) + CNT_W'(1), "push did not grow count")
endmodule

/* test/deque_checker.sv */
// Checker that mirrors the deque, predicts every result and compares it with the block's output.
`timescale 1ns / 100ps

module deque_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    cdq_req_if                        req,
    cdq_res_if                        res,
    input  logic                      cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      drain_done,
    output int                        failures
);
    import cdq_pkg::*;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic                     is_full;
    } deque_result_t;

    // Shadow copy of the deque: ring store, both ends, fill level and capacity.
    logic [DATA_W-1:0] ring_cells [DEPTH];
    logic [IDX_W-1:0]  front_idx;
    logic [IDX_W-1:0]  rear_idx;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  cap_now;

    deque_result_t awaited_results [$];
    int            mismatches = 0;
    int            leftover   = 0;

    assign failures = mismatches + leftover;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (CNT_W'(i) + CNT_W'(1) >= cap_now) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(cap_now - CNT_W'(1)) : i - IDX_W'(1);
    endfunction

    // Applies one request to the shadow deque and returns the result it should give.
    function automatic deque_result_t apply_request(input logic [REQ_W-1:0] code,
                                                    input logic [DATA_W-1:0] value);
        deque_result_t r;
        logic          was_empty;
        logic          was_full;
        r.ok         = 1'b0;
        r.read_value = '1;
        was_empty    = (fill_level == '0);
        was_full     = (fill_level >= cap_now);
        case (code)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (!was_full)
                begin
                    if (was_empty)
                    begin
                        front_idx = '0;
                        rear_idx  = '0;
                    end
                    else if (code == REQ_PUSH_FRONT)
                        front_idx = step_down(front_idx);
                    else
                        rear_idx = step_up(rear_idx);
                    ring_cells[code == REQ_PUSH_FRONT ? front_idx : rear_idx] = value;
                    fill_level = fill_level + CNT_W'(1);
                    r.ok = 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (!was_empty)
                begin
                    r.read_value = ring_cells[code == REQ_POP_FRONT ? front_idx : rear_idx];
                    if (fill_level == CNT_W'(1))
                    begin
                        front_idx = '0;
                        rear_idx  = '0;
                    end
                    else if (code == REQ_POP_FRONT)
                        front_idx = step_up(front_idx);
                    else
                        rear_idx = step_down(rear_idx);
                    fill_level = fill_level - CNT_W'(1);
                    r.ok = 1'b1;
                end
            end
            REQ_PEEK_FRONT, REQ_PEEK_REAR:
            begin
                if (!was_empty)
                begin
                    r.read_value = ring_cells[code == REQ_PEEK_FRONT ? front_idx : rear_idx];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count    = fill_level;
        r.is_empty = (fill_level == '0);
        r.is_full  = (fill_level == cap_now);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_result_t due;
        if (!rst_n)
        begin
            front_idx  = '0;
            rear_idx   = '0;
            fill_level = '0;
            cap_now    = CNT_W'(DEPTH);
            awaited_results.delete();
        end
        else
        begin
            // The oldest outstanding request is compared first; its result can
            // never leave in the same cycle as the request is taken.
            if (res.valid && res.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no request outstanding: ok=%0b value=%0d",
                                 $time, res.ok, res.read_value);
                end
                else
                begin
                    due = awaited_results.pop_front();
                    if (due.ok !== res.ok || due.read_value !== res.read_value ||
                        due.count !== res.count || due.is_empty !== res.is_empty ||
                        due.is_full !== res.is_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"[%0t] mismatch: expected ok=%0b value=%0d",
                                      " count=%0d empty=%0b full=%0b"},
                                     $time, due.ok, due.read_value, due.count,
                                     due.is_empty, due.is_full);
                            $display({"             got ok=%0b value=%0d",
                                      " count=%0d empty=%0b full=%0b"},
                                     res.ok, res.read_value, res.count, res.is_empty,
                                     res.is_full);
                        end
                    end
                end
            end
            // A capacity write clamps the value and empties the deque; the store is kept.
            if (cfg_we)
            begin
                if (cfg_wdata == '0)
                    cap_now = CNT_W'(1);
                else if (cfg_wdata > CNT_W'(DEPTH))
                    cap_now = CNT_W'(DEPTH);
                else
                    cap_now = cfg_wdata;
                front_idx  = '0;
                rear_idx   = '0;
                fill_level = '0;
            end
            if (req.valid && req.ready)
                awaited_results.push_back(apply_request(req.req_type, req.push_value));
        end
    end

    always @(posedge drain_done)
    begin
        leftover = awaited_results.size();
        if (leftover != 0)
            $display("%0d requests never received a result", leftover);
    end

endmodule

/* test/testbench.sv */
// Top of the deque testbench: clock, reset, request and result traffic, and the verdict.
`timescale 1ns / 100ps

module testbench;
    import cdq_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 80;
    localparam int PHASES      = 13;

    // Request codes that the block does not define; they must be answered as failures.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [CNT_W-1:0] cfg_wdata  = '0;
    logic             drain_done = 1'b0;
    int               failures;

    // Bookkeeping for the sender, the receiver and the closing summary.
    int requests_sent  = 0;
    int results_taken  = 0;
    int pushes_sent    = 0;
    int pops_sent      = 0;
    int peeks_sent     = 0;
    int unused_sent    = 0;
    int settings_used  = 0;
    bit sender_gappy   = 1'b0;

    cdq_req_if req_ch ();
    cdq_res_if res_ch ();

    circular_buffer_deque dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    deque_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .drain_done (drain_done),
        .failures   (failures)
    );

    always #HALF_PERIOD clk = ~clk;

    // Idle stretches are drawn from three ranges, the shortest most often; now
    // and then one is long enough to let the other side run dry.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Offers one request after the given number of idle cycles and returns at
    // the rising edge where it is taken.  The valid line is left high, so a
    // following request with no gap is offered straight away without the line
    // ever dropping in between.
    task automatic send_request(input logic [REQ_W-1:0]  code,
                                input logic [DATA_W-1:0] value,
                                input int                gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= code;
        req_ch.push_value <= value;
        do @(posedge clk); while (!req_ch.ready);
        requests_sent++;
        case (code)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:  pushes_sent++;
            REQ_POP_FRONT, REQ_POP_REAR:    pops_sent++;
            REQ_PEEK_FRONT, REQ_PEEK_REAR:  peeks_sent++;
            default:                        unused_sent++;
        endcase
    endtask

    // The capacity may only change while nothing is in flight, so the request
    // line is dropped and every outstanding result is collected first.  Each
    // request gives exactly one result, so nothing can still be at work once
    // the counts agree.
    task automatic set_capacity(input logic [CNT_W-1:0] value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (results_taken == requests_sent);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            results_taken++;
    end

    // Receiver.  It alternates between stretches where it takes every result
    // and stretches where it stalls at random.  Every four hundred and fifty
    // results or so it holds off while the sender keeps offering requests,
    // so that the output register stays full and the block refuses its input.
    initial
    begin : receiver
        int stall_left;
        int stretch_left;
        int hold_left;
        int next_hold_at;
        bit stalling;
        stall_left   = 0;
        stretch_left = 0;
        hold_left    = 0;
        next_hold_at = 150;
        stalling     = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                stalling     = ($urandom_range(0, 2) != 0);
                stretch_left = $urandom_range(20, 120);
            end
            stretch_left--;
            if (results_taken >= next_hold_at)
            begin
                hold_left    = 90;
                next_hold_at = next_hold_at + 450;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (stalling && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Sender and verdict.
    initial
    begin : sender
        logic [CNT_W-1:0]  phase_caps [PHASES];
        logic [REQ_W-1:0]  code;
        logic [DATA_W-1:0] value;
        int                roll;
        int                gap;
        int                flip_in;
        bit                filling;

        // Capacities visited by the random phases: both extremes, two values above
        // the limit that must clamp, and a spread in between.  The last phase picks
        // one at random.
        phase_caps = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd8, 5'd17,
                       5'd11, 5'd9, 5'd15, 5'd31, 5'd16};

        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.push_value = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity of sixteen.  Every request on
        // the empty deque must fail, the unused codes included.
        send_request(REQ_POP_FRONT,  32'h0000_1234, 0);
        send_request(REQ_POP_REAR,   32'h0000_1234, 0);
        send_request(REQ_PEEK_FRONT, 32'h0000_1234, 0);
        send_request(REQ_PEEK_REAR,  32'h0000_1234, 0);
        send_request(REQ_UNUSED_LO,  32'h0000_1234, 0);
        send_request(REQ_UNUSED_HI,  32'h0000_1234, 0);
        // A push into the empty deque, then pushes at both ends; the second
        // front push makes the front index wrap below zero.
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 0);
        send_request(REQ_PUSH_REAR,  32'h8000_0000, 0);
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 0);
        send_request(REQ_PUSH_REAR,  32'h0000_0000, 0);
        send_request(REQ_PEEK_FRONT, 32'h0000_0000, 0);
        send_request(REQ_PEEK_REAR,  32'h0000_0000, 0);
        send_request(REQ_POP_FRONT,  32'h0000_0000, 0);
        send_request(REQ_POP_REAR,   32'h0000_0000, 0);
        send_request(REQ_UNUSED_HI,  32'hDEAD_BEEF, 0);
        // Draining to empty: the last pop returns both ends to entry zero.
        send_request(REQ_POP_REAR,   32'h0000_0000, 0);
        send_request(REQ_POP_FRONT,  32'h0000_0000, 0);

        // A capacity of zero must clamp to one: the second push is refused
        // because the deque is already full.
        set_capacity(5'd0);
        send_request(REQ_PUSH_REAR,  32'hAAAA_AAAA, 0);
        send_request(REQ_PUSH_FRONT, 32'h5555_5555, 0);
        send_request(REQ_PEEK_REAR,  32'h0000_0000, 0);
        send_request(REQ_POP_FRONT,  32'h0000_0000, 0);
        send_request(REQ_POP_REAR,   32'h0000_0000, 0);

        // Random phases.  Each alternates between filling and draining bursts
        // so that the deque keeps reaching both full and empty, and the
        // indices wrap many times at every capacity.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES - 1)
                set_capacity(CNT_W'($urandom_range(1, DEPTH)));
            else
                set_capacity(phase_caps[phase]);
            sender_gappy = (phase % 3 != 0);
            filling      = 1'b1;
            flip_in      = $urandom_range(4, 40);
            repeat (PHASE_ITEMS)
            begin
                if (flip_in == 0)
                begin
                    filling = !filling;
                    flip_in = $urandom_range(4, 40);
                end
                flip_in--;

                roll = $urandom_range(0, 99);
                if (roll < 3)
                    code = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
                else if (roll < (filling ? 65 : 28))
                    code = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                else if (roll < 82)
                    code = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
                else
                    code = $urandom_range(0, 1) ? REQ_PEEK_REAR : REQ_PEEK_FRONT;

                case ($urandom_range(0, 19))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = '1;
                    3:       value = '0;
                    default: value = $urandom;
                endcase

                gap = (sender_gappy && $urandom_range(0, 2) == 0) ? idle_length() : 0;
                send_request(code, value, gap);
            end
        end

        // Wind down: stop offering, collect every result, then allow a few
        // cycles for anything unexpected to appear.
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (results_taken == requests_sent);
        repeat (5) @(posedge clk);
        @(negedge clk);
        drain_done <= 1'b1;
        @(posedge clk);

        $display("Sent %0d requests (%0d pushes, %0d pops, %0d peeks, %0d unused codes)",
                 requests_sent, pushes_sent, pops_sent, peeks_sent, unused_sent);
        $display("over %0d capacity writes; %0d results were checked, %0d failures.",
                 settings_used, results_taken, failures);
        if (failures == 0)
            $display("circular_buffer_deque verification clean");
        else
            $display("circular_buffer_deque verification failed");
        $finish;
    end

    // Watchdog: the slowest legal run is far below this many cycles.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles: %0d requests sent, %0d results taken.",
                 cycles, requests_sent, results_taken);
        $display("circular_buffer_deque verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_req_if.sv
rtl/core/cdq_res_if.sv
rtl/core/cdq_cell.sv
rtl/core/circular_buffer_deque.sv
test/deque_checker.sv
test/testbench.sv
